>>> src/cft_pkg.sv
// cft_pkg: shared constants and types of the csv field tokenizer
// no dependencies; imported by every module of the block
`default_nettype none

package cft_pkg;

    // field store geometry
    localparam int MAX_FIELD_BYTES = 32;
    localparam int LEN_W           = $clog2(MAX_FIELD_BYTES + 1);
    localparam int IDX_W           = (MAX_FIELD_BYTES > 1) ? $clog2(MAX_FIELD_BYTES) : 1;
    localparam int NUM_BANKS       = 2;
    localparam int ADDR_W          = IDX_W + 1;

    // command queue depth
    localparam int QUEUE_DEPTH     = 2;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

    // byte codes
    localparam logic [7:0] QUOTE_BYTE      = 8'h22;
    localparam logic [7:0] RESET_SEPARATOR = 8'd44;
    localparam logic [7:0] TERM_NUL        = 8'h00;
    localparam logic [7:0] TERM_LF         = 8'h0A;
    localparam logic [7:0] TERM_CR         = 8'h0D;

    // status codes
    localparam logic [1:0] STATUS_MORE      = 2'd0;
    localparam logic [1:0] STATUS_END       = 2'd1;
    localparam logic [1:0] STATUS_UNMATCHED = 2'd2;
    localparam logic [1:0] STATUS_TOO_LONG  = 2'd3;

    // one completed field or error, handed from parser to emitter
    typedef struct packed {
        logic             bank;
        logic [LEN_W-1:0] len;
        logic [1:0]       status;
    } t_cmd;

    // write port into the field store
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_wr;

    // bank released by the emitter
    typedef struct packed {
        logic valid;
        logic bank;
    } t_rel;

endpackage

`default_nettype wire

>>> src/csv_field_tokenizer_top.sv
// csv field tokenizer: with the emitter idle, a field with data passes from the word
// that completes it through the queue, emitter command, read data and output registers;
// empty or error words go from the queue straight to the output register. Bytes play out
// by a read-then-load loop on the store port; idle follows each data field. Input takes a
// word per cycle while a free store bank and queue slot exist. Synchronous active-low
// reset clears parser state, queue and output valid; separator returns to comma.
`default_nettype none

module csv_field_tokenizer_top import cft_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [7:0] i_cfg_data,
    input  wire logic       i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    input  wire logic [7:0] i_s_axis_tdata,   // [7:0] byte_in
    output logic            o_m_axis_tvalid,
    input  wire logic       i_m_axis_tready,
    output logic [7:0]      o_m_axis_tdata,   // [7:0] token_byte
    output logic [2:0]      o_m_axis_tuser,   // [0] byte_valid, [2:1] status
    output logic            o_m_axis_tlast    // last_of_token
);

    logic queue_full, queue_empty, push, pop;
    t_cmd cmd, head;
    t_wr  wr;
    t_rel rel;
    logic       obv;
    logic [1:0] ostat;

    assign o_cfg_ready = 1'b1;

    // parser front
    cft_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_byte_valid (i_s_axis_tvalid),
        .i_byte       (i_s_axis_tdata),
        .o_byte_ready (o_s_axis_tready),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_cmd        (cmd),
        .o_wr         (wr),
        .i_rel        (rel)
    );

    // command queue
    cft_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (queue_empty),
        .o_full  (queue_full)
    );

    // emitter back
    cft_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr         (wr),
        .i_head       (head),
        .i_empty      (queue_empty),
        .o_pop        (pop),
        .o_rel        (rel),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_byte       (o_m_axis_tdata),
        .o_byte_valid (obv),
        .o_last       (o_m_axis_tlast),
        .o_status     (ostat)
    );

    assign o_m_axis_tuser = {ostat, obv};

endmodule

`default_nettype wire

>>> src/cft_front.sv
// cft_front: byte parser; classifies each word, writes field bytes, queues commands
// depends on cft_pkg
`default_nettype none

module cft_front import cft_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_valid,
    input  wire logic [7:0] i_cfg_data,
    input  wire logic       i_byte_valid,
    input  wire logic [7:0] i_byte,
    output logic            o_byte_ready,
    input  wire logic       i_queue_full,
    output logic            o_push,
    output t_cmd            o_cmd,
    output t_wr             o_wr,
    input  wire t_rel       i_rel
);

    localparam logic [2:0] MODE_START_AFTER_TERM = 3'd0;
    localparam logic [2:0] MODE_START            = 3'd1;
    localparam logic [2:0] MODE_UNQUOTED         = 3'd2;
    localparam logic [2:0] MODE_QUOTED           = 3'd3;
    localparam logic [2:0] MODE_QUOTE_SEEN       = 3'd4;
    localparam logic [2:0] MODE_DROP             = 3'd5;

    logic [7:0]           r_sep;
    logic [2:0]           r_mode, n_mode;
    logic [LEN_W-1:0]     r_len, n_len;
    logic                 r_wbank, n_wbank;
    logic [NUM_BANKS-1:0] r_busy, n_busy;

    logic accept, term, sep, quote, full;
    logic store, push, err;
    logic [1:0] push_status;

    // separator register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep <= RESET_SEPARATOR;
        end else if (i_cfg_valid) begin
            r_sep <= i_cfg_data;
        end
    end

    // byte classes
    assign o_byte_ready = !i_queue_full && !r_busy[r_wbank];
    assign accept = i_byte_valid && o_byte_ready;
    assign term   = (i_byte == TERM_NUL) || (i_byte == TERM_LF) || (i_byte == TERM_CR);
    assign sep    = !term && (i_byte == r_sep);
    assign quote  = (i_byte == QUOTE_BYTE);
    assign full   = (r_len >= LEN_W'(MAX_FIELD_BYTES));

    // parse step
    always_comb begin
        n_mode      = r_mode;
        store       = 1'b0;
        push        = 1'b0;
        err         = 1'b0;
        push_status = STATUS_MORE;
        case (r_mode)
            MODE_START_AFTER_TERM, MODE_START: begin
                if (term) begin
                    if (r_mode == MODE_START) begin
                        push        = 1'b1;
                        push_status = STATUS_END;
                    end
                    n_mode = MODE_START_AFTER_TERM;
                end else if (quote) begin
                    n_mode = MODE_QUOTED;
                end else if (sep) begin
                    push   = 1'b1;
                    n_mode = MODE_START;
                end else begin
                    store  = 1'b1;
                    n_mode = MODE_UNQUOTED;
                end
            end
            MODE_UNQUOTED: begin
                if (term) begin
                    push        = 1'b1;
                    push_status = STATUS_END;
                    n_mode      = MODE_START_AFTER_TERM;
                end else if (sep) begin
                    push   = 1'b1;
                    n_mode = MODE_START;
                end else if (full) begin
                    err         = 1'b1;
                    push_status = STATUS_TOO_LONG;
                end else begin
                    store = 1'b1;
                end
            end
            MODE_QUOTED: begin
                if (term) begin
                    err         = 1'b1;
                    push_status = STATUS_UNMATCHED;
                end else if (quote) begin
                    n_mode = MODE_QUOTE_SEEN;
                end else if (full) begin
                    err         = 1'b1;
                    push_status = STATUS_TOO_LONG;
                end else begin
                    store = 1'b1;
                end
            end
            MODE_QUOTE_SEEN: begin
                if (quote) begin
                    if (full) begin
                        err         = 1'b1;
                        push_status = STATUS_TOO_LONG;
                    end else begin
                        store  = 1'b1;
                        n_mode = MODE_QUOTED;
                    end
                end else if (term) begin
                    push        = 1'b1;
                    push_status = STATUS_END;
                    n_mode      = MODE_START_AFTER_TERM;
                end else if (sep) begin
                    push   = 1'b1;
                    n_mode = MODE_START;
                end else begin
                    err         = 1'b1;
                    push_status = STATUS_TOO_LONG;
                end
            end
            default: begin
                n_mode = term ? MODE_START_AFTER_TERM : MODE_DROP;
            end
        endcase
        if (err) begin
            push   = 1'b1;
            n_mode = term ? MODE_START_AFTER_TERM : MODE_DROP;
        end
    end

    // length, bank and command
    always_comb begin
        o_cmd.bank   = r_wbank;
        o_cmd.status = push_status;
        o_cmd.len    = err ? '0 : r_len;
        o_push       = accept && push;
        n_wbank      = r_wbank;
        n_busy       = r_busy;
        if (i_rel.valid) begin
            n_busy[i_rel.bank] = 1'b0;
        end
        if (push || err || (r_mode == MODE_DROP) || (r_mode == MODE_START)
            || (r_mode == MODE_START_AFTER_TERM)) begin
            n_len = '0;
        end else begin
            n_len = r_len;
        end
        if (store) begin
            n_len = n_len + LEN_W'(1);
        end
        if (o_push && !err && (r_len != '0)) begin
            n_wbank         = !r_wbank;
            n_busy[r_wbank] = 1'b1;
        end
        o_wr.en   = accept && store;
        o_wr.addr = {r_wbank, IDX_W'(n_len - LEN_W'(1))};
        o_wr.data = i_byte;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_START_AFTER_TERM;
            r_len   <= '0;
            r_wbank <= 1'b0;
            r_busy  <= '0;
        end else begin
            r_busy <= n_busy;
            if (accept) begin
                r_mode  <= n_mode;
                r_len   <= n_len;
                r_wbank <= n_wbank;
            end
        end
    end

endmodule

`default_nettype wire

>>> src/cft_cmd_fifo.sv
// cft_cmd_fifo: short queue of field commands between parser and emitter
// depends on cft_pkg
`default_nettype none

module cft_cmd_fifo import cft_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output t_cmd      o_head,
    output logic      o_empty,
    output logic      o_full
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;

    assign o_head  = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

>>> src/cft_back.sv
// cft_back: field store and emitter; plays queued fields out one byte per word
// depends on cft_pkg
`default_nettype none

module cft_back import cft_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_wr  i_wr,
    input  wire t_cmd i_head,
    input  wire logic i_empty,
    output logic      o_pop,
    output t_rel      o_rel,
    output logic      o_valid,
    input  wire logic i_ready,
    output logic [7:0] o_byte,
    output logic      o_byte_valid,
    output logic      o_last,
    output logic [1:0] o_status
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [7:0]       r_store [MAX_FIELD_BYTES * NUM_BANKS];
    logic [7:0]       r_rdata;
    logic [1:0]       r_state, n_state;
    t_cmd             r_cmd;
    logic [IDX_W-1:0] r_idx;
    logic             r_ovalid;
    logic [7:0]       r_obyte;
    logic             r_obv, r_olast;
    logic [1:0]       r_ostat;

    logic out_free, is_last, load_empty, load_byte, take;

    // field store, registered read
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_store[i_wr.addr] <= i_wr.data;
        end
        r_rdata <= r_store[{r_cmd.bank, r_idx}];
    end

    // emitter control
    assign out_free   = !r_ovalid || i_ready;
    assign is_last    = ((LEN_W'(r_idx) + LEN_W'(1)) == r_cmd.len);
    assign load_empty = (r_state == S_IDLE) && !i_empty && (i_head.len == '0) && out_free;
    assign take       = (r_state == S_IDLE) && !i_empty && (i_head.len != '0);
    assign load_byte  = (r_state == S_OUT) && out_free;
    assign o_pop      = load_empty || take;
    assign o_rel.valid = load_byte && is_last;
    assign o_rel.bank  = r_cmd.bank;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (take) n_state = S_RD;
            S_RD:   n_state = S_OUT;
            S_OUT:  if (load_byte) n_state = is_last ? S_IDLE : S_RD;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_empty || load_byte) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // command, index and output word
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd <= i_head;
            r_idx <= '0;
        end else if (load_byte && !is_last) begin
            r_idx <= r_idx + IDX_W'(1);
        end
        if (load_empty) begin
            r_obyte <= 8'd0;
            r_obv   <= 1'b0;
            r_olast <= 1'b1;
            r_ostat <= i_head.status;
        end else if (load_byte) begin
            r_obyte <= r_rdata;
            r_obv   <= 1'b1;
            r_olast <= is_last;
            r_ostat <= r_cmd.status;
        end
    end

    assign o_valid      = r_ovalid;
    assign o_byte       = r_obyte;
    assign o_byte_valid = r_obv;
    assign o_last       = r_olast;
    assign o_status     = r_ostat;

endmodule

`default_nettype wire
